// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL modules; timestamp_text_parse_validate includes them.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication check.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

// ===== hw/rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

    // Input transaction: one character of the timestamp text
    typedef struct packed {
        logic [7:0] char_code;
        logic       first_char;
    } in_t;

    // Output transaction: one parsed and checked timestamp
    typedef struct packed {
        logic        date_ok;
        logic [13:0] year_value;
        logic [3:0]  month_value;
        logic [4:0]  day_value;
        logic [4:0]  hour_value;
        logic [5:0]  minute_value;
    } out_t;

    // Accumulated fields handed to the calendar checker
    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  century;
        logic [6:0]  year_in_century;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
    } date_fields_t;

    // Character codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Character positions in YYYY-MM-DD/HH:MM
    localparam logic [3:0] POS_YY_FIRST = 4'd2;
    localparam logic [3:0] POS_SEP_YM   = 4'd4;
    localparam logic [3:0] POS_SEP_MD   = 4'd7;
    localparam logic [3:0] POS_SEP_DT   = 4'd10;
    localparam logic [3:0] POS_SEP_HM   = 4'd13;
    localparam logic [3:0] POS_LAST     = 4'd15;

    // Calendar limits
    localparam logic [13:0] YEAR_MIN      = 14'd1000;
    localparam logic [13:0] YEAR_MAX      = 14'd9999;
    localparam logic [6:0]  MONTH_MAX     = 7'd12;
    localparam logic [6:0]  MONTH_FEB     = 7'd2;
    localparam logic [6:0]  MONTH_APR     = 7'd4;
    localparam logic [6:0]  MONTH_JUN     = 7'd6;
    localparam logic [6:0]  MONTH_SEP     = 7'd9;
    localparam logic [6:0]  MONTH_NOV     = 7'd11;
    localparam logic [6:0]  DAY_MAX       = 7'd31;
    localparam logic [6:0]  DAY_MAX_SHORT = 7'd30;
    localparam logic [6:0]  DAY_MAX_LEAP  = 7'd29;
    localparam logic [6:0]  DAY_MAX_FEB   = 7'd28;
    localparam logic [6:0]  HOUR_MAX      = 7'd23;
    localparam logic [6:0]  MINUTE_MAX    = 7'd59;

    // Multiply by ten and add one decimal digit, wrapping at 14 bits
    function automatic logic [13:0] dec_push14(input logic [13:0] acc, input logic [3:0] digit);
        return (acc << 3) + (acc << 1) + {10'd0, digit};
    endfunction

    // Multiply by ten and add one decimal digit, wrapping at 7 bits
    function automatic logic [6:0] dec_push7(input logic [6:0] acc, input logic [3:0] digit);
        return (acc << 3) + (acc << 1) + {3'd0, digit};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/timestamp_text_parse_validate.sv =====
// Throughput: one character per cycle, sustained, with no stall while out_stall is low.
// A character is held in the input register; the sixteenth character of a timestamp
// then loads the result register, which raises out_valid. A result held by out_stall
// blocks input only once the next sixteenth character reaches the input register.
// Reset clears the position counter, all accumulators and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_text_parse_validate
    import tsp_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire in_t   in_item,
    output logic       out_valid,
    input  wire        out_stall,
    output out_t       out_item
);

`include "assert_macros.svh"

    // Input register
    logic s0_valid_reg;
    in_t  s0_item_reg;

    // Parse state
    logic [3:0]  pos_reg;
    logic        bad_reg;
    logic [13:0] year_reg;
    logic [6:0]  cent_reg;
    logic [6:0]  yy_reg;
    logic [6:0]  month_reg;
    logic [6:0]  day_reg;
    logic [6:0]  hour_reg;
    logic [6:0]  minute_reg;

    // Result register
    logic out_valid_reg;
    out_t out_item_reg;

    logic [3:0]   base_pos;
    logic         is_digit;
    logic [3:0]   digit;
    logic         is_last;
    logic         s0_go;
    logic         bad_next;
    date_fields_t fields_next;
    logic         date_valid;
    logic         result_ok;
    out_t         out_item_next;

    // Restart from position zero on a start mark
    assign base_pos = s0_item_reg.first_char ? 4'd0 : pos_reg;
    assign is_last  = (base_pos == POS_LAST);
    assign is_digit = (s0_item_reg.char_code >= CHAR_ZERO) &&
                      (s0_item_reg.char_code <= CHAR_NINE);
    assign digit    = is_digit ? 4'(s0_item_reg.char_code - CHAR_ZERO) : 4'd0;

    // Advance the input register unless a finished result is blocked downstream
    assign s0_go    = s0_valid_reg && (!is_last || !out_valid_reg || !out_stall);
    assign in_stall = s0_valid_reg && !s0_go;

    // Check the separator or push the digit into its field
    always_comb
    begin
        if (s0_item_reg.first_char)
        begin
            bad_next    = 1'b0;
            fields_next = '0;
        end
        else
        begin
            bad_next                    = bad_reg;
            fields_next.year            = year_reg;
            fields_next.century         = cent_reg;
            fields_next.year_in_century = yy_reg;
            fields_next.month           = month_reg;
            fields_next.day             = day_reg;
            fields_next.hour            = hour_reg;
            fields_next.minute          = minute_reg;
        end

        case (base_pos)
            POS_SEP_YM, POS_SEP_MD:
            begin
                if (s0_item_reg.char_code != CHAR_DASH)
                begin
                    bad_next = 1'b1;
                end
            end
            POS_SEP_DT:
            begin
                if (s0_item_reg.char_code != CHAR_SLASH)
                begin
                    bad_next = 1'b1;
                end
            end
            POS_SEP_HM:
            begin
                if (s0_item_reg.char_code != CHAR_COLON)
                begin
                    bad_next = 1'b1;
                end
            end
            default:
            begin
                if (!is_digit)
                begin
                    bad_next = 1'b1;
                end
                else if (base_pos < POS_SEP_YM)
                begin
                    fields_next.year = dec_push14(fields_next.year, digit);
                    if (base_pos < POS_YY_FIRST)
                    begin
                        fields_next.century = dec_push7(fields_next.century, digit);
                    end
                    else
                    begin
                        fields_next.year_in_century =
                            dec_push7(fields_next.year_in_century, digit);
                    end
                end
                else if (base_pos < POS_SEP_MD)
                begin
                    fields_next.month = dec_push7(fields_next.month, digit);
                end
                else if (base_pos < POS_SEP_DT)
                begin
                    fields_next.day = dec_push7(fields_next.day, digit);
                end
                else if (base_pos < POS_SEP_HM)
                begin
                    fields_next.hour = dec_push7(fields_next.hour, digit);
                end
                else
                begin
                    fields_next.minute = dec_push7(fields_next.minute, digit);
                end
            end
        endcase
    end

    tsp_calendar_chk u_calendar_chk (
        .fields     (fields_next),
        .date_valid (date_valid)
    );

    // Build the result, zeroed when any check fails
    always_comb
    begin
        result_ok = !bad_next && date_valid;
        if (result_ok)
        begin
            out_item_next.date_ok      = 1'b1;
            out_item_next.year_value   = fields_next.year;
            out_item_next.month_value  = fields_next.month[3:0];
            out_item_next.day_value    = fields_next.day[4:0];
            out_item_next.hour_value   = fields_next.hour[4:0];
            out_item_next.minute_value = fields_next.minute[5:0];
        end
        else
        begin
            out_item_next = '0;
        end
    end

    // Load the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s0_item_reg <= in_item;
        end
    end

    // Advance the parse state; clear it after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 4'd0;
            bad_reg    <= 1'b0;
            year_reg   <= 14'd0;
            cent_reg   <= 7'd0;
            yy_reg     <= 7'd0;
            month_reg  <= 7'd0;
            day_reg    <= 7'd0;
            hour_reg   <= 7'd0;
            minute_reg <= 7'd0;
        end
        else if (s0_go)
        begin
            if (is_last)
            begin
                pos_reg    <= 4'd0;
                bad_reg    <= 1'b0;
                year_reg   <= 14'd0;
                cent_reg   <= 7'd0;
                yy_reg     <= 7'd0;
                month_reg  <= 7'd0;
                day_reg    <= 7'd0;
                hour_reg   <= 7'd0;
                minute_reg <= 7'd0;
            end
            else
            begin
                pos_reg    <= base_pos + 4'd1;
                bad_reg    <= bad_next;
                year_reg   <= fields_next.year;
                cent_reg   <= fields_next.century;
                yy_reg     <= fields_next.year_in_century;
                month_reg  <= fields_next.month;
                day_reg    <= fields_next.day;
                hour_reg   <= fields_next.hour;
                minute_reg <= fields_next.minute;
            end
        end
    end

    // Load the result register; drop valid once the transaction is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s0_go && is_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_go && is_last)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Input backs up only behind a blocked result
    `ASSERT_IMPL(a_stall_cause, in_stall, out_valid_reg && out_stall && is_last)
    // The last character always produces a result and restarts the position
    `ASSERT_NEXT(a_last_result, s0_go && is_last, out_valid_reg && (pos_reg == 4'd0))
    // A failed timestamp carries all-zero fields
    `ASSERT_IMPL(a_fail_zero, out_valid_reg && !out_item_reg.date_ok,
                 out_item_reg == '0)
    // A passed timestamp has a plausible date
    `ASSERT_IMPL(a_ok_range, out_valid_reg && out_item_reg.date_ok,
                 (out_item_reg.year_value >= YEAR_MIN) &&
                 (out_item_reg.month_value != 4'd0) && (out_item_reg.day_value != 5'd0))

endmodule

`default_nettype wire

// ===== hw/rtl/tsp_calendar_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsp_calendar_chk
    import tsp_pkg::*;
(
    input  wire date_fields_t fields,
    output logic              date_valid
);

    logic leap_year;
    logic short_month;
    logic day_fits;

    // Leap year: divisible by 4 and not by 100, or divisible by 400.
    // With a two-digit split, 100 divides the year when the low pair is zero,
    // and then 400 divides it when 4 divides the century.
    always_comb
    begin
        if (fields.year_in_century == 7'd0)
        begin
            leap_year = (fields.century[1:0] == 2'd0);
        end
        else
        begin
            leap_year = (fields.year_in_century[1:0] == 2'd0);
        end
    end

    // Apply the per-month day limit
    always_comb
    begin
        short_month = (fields.month == MONTH_APR) || (fields.month == MONTH_JUN) ||
                      (fields.month == MONTH_SEP) || (fields.month == MONTH_NOV);
        if (fields.month == MONTH_FEB)
        begin
            day_fits = leap_year ? (fields.day <= DAY_MAX_LEAP) : (fields.day <= DAY_MAX_FEB);
        end
        else if (short_month)
        begin
            day_fits = (fields.day <= DAY_MAX_SHORT);
        end
        else
        begin
            day_fits = (fields.day <= DAY_MAX);
        end
    end

    // Combine range checks
    assign date_valid = (fields.year >= YEAR_MIN) && (fields.year <= YEAR_MAX) &&
                        (fields.month != 7'd0) && (fields.month <= MONTH_MAX) &&
                        (fields.day != 7'd0) && day_fits &&
                        (fields.hour <= HOUR_MAX) && (fields.minute <= MINUTE_MAX);

endmodule

`default_nettype wire

// ===== tb/tb_timestamp_text_parse_validate.sv =====
`timescale 1ns / 1ps

module tb_timestamp_text_parse_validate;
    import tsp_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_CHARS   = 360;
    localparam int NUM_PHASES    = 4;
    localparam logic [7:0] BYTE_NUL      = 8'h00;
    localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

    // One timestamp text, position 0 at index 0
    typedef logic [15:0][7:0] stamp_t;

    // Track the parse of the character stream and hold the timestamps it must produce
    class date_scoreboard;
        logic [3:0]  pos;
        bit          bad;
        logic [13:0] year_acc;
        logic [6:0]  month_acc;
        logic [6:0]  day_acc;
        logic [6:0]  hour_acc;
        logic [6:0]  minute_acc;
        out_t        expected_q[$];
        int          errors;

        function void clear_text();
            pos = '0;
            bad = 1'b0;
            year_acc = '0;
            month_acc = '0;
            day_acc = '0;
            hour_acc = '0;
            minute_acc = '0;
        endfunction

        function bit calendar_ok();
            bit leap;
            leap = ((year_acc % 4 == 0) && (year_acc % 100 != 0)) || (year_acc % 400 == 0);
            if (year_acc < YEAR_MIN || year_acc > YEAR_MAX) return 1'b0;
            if (month_acc < 1 || month_acc > MONTH_MAX) return 1'b0;
            if (day_acc < 1 || day_acc > DAY_MAX) return 1'b0;
            if (hour_acc > HOUR_MAX || minute_acc > MINUTE_MAX) return 1'b0;
            if ((month_acc == MONTH_APR || month_acc == MONTH_JUN || month_acc == MONTH_SEP
                 || month_acc == MONTH_NOV) && day_acc > DAY_MAX_SHORT)
                return 1'b0;
            if (month_acc == MONTH_FEB && day_acc > (leap ? DAY_MAX_LEAP : DAY_MAX_FEB))
                return 1'b0;
            return 1'b1;
        endfunction

        // Advance the parse by one accepted character
        function void note_char(in_t c);
            bit         is_digit;
            logic [3:0] digit;
            out_t       want;
            if (c.first_char || pos == 0) clear_text();
            is_digit = (c.char_code >= CHAR_ZERO) && (c.char_code <= CHAR_NINE);
            digit = is_digit ? 4'(c.char_code - CHAR_ZERO) : 4'd0;
            case (pos)
                POS_SEP_YM, POS_SEP_MD: if (c.char_code != CHAR_DASH) bad = 1'b1;
                POS_SEP_DT:             if (c.char_code != CHAR_SLASH) bad = 1'b1;
                POS_SEP_HM:             if (c.char_code != CHAR_COLON) bad = 1'b1;
                default:
                begin
                    if (!is_digit)
                        bad = 1'b1;
                    else if (pos < POS_SEP_YM)
                        year_acc = 14'(int'(year_acc) * 10 + digit);
                    else if (pos < POS_SEP_MD)
                        month_acc = 7'(int'(month_acc) * 10 + digit);
                    else if (pos < POS_SEP_DT)
                        day_acc = 7'(int'(day_acc) * 10 + digit);
                    else if (pos < POS_SEP_HM)
                        hour_acc = 7'(int'(hour_acc) * 10 + digit);
                    else
                        minute_acc = 7'(int'(minute_acc) * 10 + digit);
                end
            endcase
            if (pos != POS_LAST)
            begin
                pos = pos + 4'd1;
                return;
            end
            // Last character: queue the checked timestamp and start over
            want = '0;
            if (!bad && calendar_ok())
            begin
                want.date_ok = 1'b1;
                want.year_value = year_acc;
                want.month_value = month_acc[3:0];
                want.day_value = day_acc[4:0];
                want.hour_value = hour_acc[4:0];
                want.minute_value = minute_acc[5:0];
            end
            expected_q.push_back(want);
            clear_text();
        endfunction

        // Compare one accepted timestamp with the oldest one still owed
        function void check_result(out_t got);
            out_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected timestamp: ok=%0d %0d-%0d-%0d %0d:%0d",
                             got.date_ok, got.year_value, got.month_value, got.day_value,
                             got.hour_value, got.minute_value);
                return;
            end
            want = expected_q.pop_front();
            if (got.date_ok !== want.date_ok || got.year_value !== want.year_value
                || got.month_value !== want.month_value || got.day_value !== want.day_value
                || got.hour_value !== want.hour_value || got.minute_value !== want.minute_value)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: exp %0d %0d-%0d-%0d %0d:%0d, got %0d %0d-%0d-%0d %0d:%0d",
                             want.date_ok, want.year_value, want.month_value, want.day_value,
                             want.hour_value, want.minute_value,
                             got.date_ok, got.year_value, got.month_value, got.day_value,
                             got.hour_value, got.minute_value);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t  in_item;
    logic out_valid;
    logic out_stall;
    out_t out_item;

    date_scoreboard sb = new;
    int send_idle_pct;
    int stall_pct;
    int chars_sent;
    int quiet_cycles;
    bit restart_next;

    timestamp_text_parse_validate i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stall the result channel at random
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Check every accepted result transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
    end

    // Count cycles without any transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] dig(int unsigned v);
        return CHAR_ZERO + 8'(v % 10);
    endfunction

    function automatic stamp_t make_stamp(int unsigned y, int unsigned mo, int unsigned d,
                                          int unsigned h, int unsigned mi);
        stamp_t s;
        s[0] = dig(y / 1000);
        s[1] = dig(y / 100);
        s[2] = dig(y / 10);
        s[3] = dig(y);
        s[4] = CHAR_DASH;
        s[5] = dig(mo / 10);
        s[6] = dig(mo);
        s[7] = CHAR_DASH;
        s[8] = dig(d / 10);
        s[9] = dig(d);
        s[10] = CHAR_SLASH;
        s[11] = dig(h / 10);
        s[12] = dig(h);
        s[13] = CHAR_COLON;
        s[14] = dig(mi / 10);
        s[15] = dig(mi);
        return s;
    endfunction

    // Offer one character, hold it until accepted; starts and ends at a falling edge
    task automatic send_char(in_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_char(c);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(stamp_t s, int len, bit mark);
        in_t c;
        for (int i = 0; i < len; i++)
        begin
            c.char_code = s[i];
            c.first_char = (i == 0) ? mark : 1'b0;
            send_char(c);
        end
    endtask

    task automatic run_directed();
        stamp_t s;
        // calendar extremes and leap rules
        send_text(make_stamp(1000, 1, 1, 0, 0), 16, 1'b1);
        send_text(make_stamp(9999, 12, 31, 23, 59), 16, 1'b1);
        send_text(make_stamp(2000, 2, 29, 12, 30), 16, 1'b1);
        send_text(make_stamp(1900, 2, 29, 8, 15), 16, 1'b1);
        send_text(make_stamp(2024, 2, 29, 1, 1), 16, 1'b1);
        send_text(make_stamp(2023, 2, 29, 1, 1), 16, 1'b1);
        send_text(make_stamp(2023, 2, 28, 1, 1), 16, 1'b1);
        send_text(make_stamp(2023, 4, 31, 10, 10), 16, 1'b1);
        send_text(make_stamp(999, 6, 15, 10, 10), 16, 1'b1);
        // field ranges just outside the limits
        send_text(make_stamp(2010, 0, 10, 10, 10), 16, 1'b1);
        send_text(make_stamp(2010, 13, 10, 10, 10), 16, 1'b1);
        send_text(make_stamp(2010, 5, 0, 10, 10), 16, 1'b1);
        send_text(make_stamp(2010, 5, 32, 10, 10), 16, 1'b1);
        send_text(make_stamp(2010, 5, 10, 24, 10), 16, 1'b1);
        send_text(make_stamp(2010, 5, 10, 10, 60), 16, 1'b1);
        // wrong separators, non-digits next to the digit range, and extreme byte values
        s = make_stamp(2010, 5, 10, 10, 10);
        s[10] = CHAR_DASH;
        s[4] = CHAR_SLASH;
        send_text(s, 16, 1'b1);
        s = make_stamp(2010, 5, 10, 10, 10);
        s[13] = CHAR_DASH;
        s[7] = CHAR_ZERO;
        send_text(s, 16, 1'b1);
        s = make_stamp(2010, 5, 10, 10, 10);
        s[2] = CHAR_COLON;
        send_text(s, 16, 1'b1);
        s = make_stamp(2010, 5, 10, 10, 10);
        s[11] = CHAR_SLASH;
        s[5] = BYTE_ALL_ONES;
        s[15] = BYTE_NUL;
        send_text(s, 16, 1'b1);
        // restart in the middle of a text
        send_text(make_stamp(1999, 12, 31, 23, 59), 7, 1'b1);
        send_text(make_stamp(2400, 2, 29, 0, 0), 16, 1'b1);
        // unmarked texts back to back
        send_text(make_stamp(2100, 2, 29, 6, 6), 16, 1'b0);
        send_text(make_stamp(1600, 2, 29, 6, 6), 16, 1'b0);
    endtask

    // One random text: mostly well-formed, some corrupted, cut short or noise
    task automatic random_text();
        stamp_t      s;
        int unsigned y, mo, d, h, mi;
        int          kind;
        int          r;
        bit          mark;
        in_t         c;
        r = $urandom_range(0, 9);
        case (r)
            0: y = 1000;
            1: y = 9999;
            2: y = $urandom_range(0, 999);
            3: y = 100 * $urandom_range(10, 99);
            4: y = 400 * $urandom_range(3, 24);
            default: y = $urandom_range(1000, 9999);
        endcase
        mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 13);
        if ($urandom_range(0, 9) == 0)
            d = $urandom_range(0, 99);
        else if ($urandom_range(0, 1) == 0)
            d = $urandom_range(27, 31);
        else
            d = $urandom_range(0, 32);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 25);
        mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 61);
        s = make_stamp(y, mo, d, h, mi);
        mark = restart_next ? 1'b1 : 1'($urandom_range(0, 1));
        restart_next = 1'b0;
        kind = $urandom_range(0, 99);
        if (kind < 60)
            send_text(s, 16, mark);
        else if (kind < 75)
        begin
            s[$urandom_range(0, 15)] = 8'($urandom_range(0, 255));
            send_text(s, 16, mark);
        end
        else if (kind < 88)
        begin
            send_text(s, $urandom_range(1, 15), mark);
            restart_next = 1'b1;
        end
        else
        begin
            for (int i = $urandom_range(1, 20); i > 0; i--)
            begin
                c.char_code = 8'($urandom_range(0, 255));
                c.first_char = ($urandom_range(0, 7) == 0);
                send_char(c);
            end
            restart_next = ($urandom_range(0, 3) != 0);
        end
    endtask

    initial
    begin
        int stop_at;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        chars_sent = 0;
        restart_next = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();

        // random phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 48; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 48; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            stop_at = chars_sent + PHASE_CHARS;
            while (chars_sent < stop_at)
                random_text();
        end
        in_valid <= 1'b0;

        // drain the results still owed
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.errors++;

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
